FILE: rtl/core/khbt_pkg.sv
// Package for the keyed hash bucket table: sizes, status codes, FSM states,
// controller/datapath command and status words, SipHash round function.
// No dependencies.
package khbt_pkg;

    localparam int NUM_BUCKETS   = 16;
    localparam int BUCKET_SLOTS  = 10;
    localparam int MAX_KEY_BYTES = 32;
    localparam int VALUE_BITS    = 16;
    localparam int KEY_WORDS     = (MAX_KEY_BYTES + 7) / 8;
    localparam int TOTAL_SLOTS   = NUM_BUCKETS * BUCKET_SLOTS;
    localparam int BKT_W         = $clog2(NUM_BUCKETS);
    localparam int SLOT_W        = 4;
    localparam int ADDR_W        = $clog2(TOTAL_SLOTS);
    localparam int CNT_W         = 6;
    localparam int WSEL_W        = 3;
    localparam int KEY_BITS      = KEY_WORDS * 64;

    localparam logic [63:0] HASH_KEY_LOW_RST  = 64'h0706050403020100;
    localparam logic [63:0] HASH_KEY_HIGH_RST = 64'h0F0E0D0C0B0A0908;
    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_HIT      = 3'd1,
        ST_MISS     = 3'd2,
        ST_FULL     = 3'd3,
        ST_TOO_LONG = 3'd4
    } khbt_status_t;

    typedef enum logic [3:0] {
        S_COLLECT,
        S_CHECK,
        S_ABS_A,
        S_ABS_B,
        S_FIN,
        S_BUCKET,
        S_DECIDE,
        S_WRITE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RESULT
    } khbt_state_t;

    typedef logic [3:0][63:0] sip_v_t;

    typedef struct packed {
        logic                in_ready;
        logic                init_v;
        logic                rnd;
        logic                pre_m;
        logic                post_m;
        logic                fin_x;
        logic [WSEL_W-1:0]   word;
        logic                latch_bkt;
        logic                wr_slot;
        logic                rd_slot;
        logic [SLOT_W-1:0]   slot;
        logic                load_out;
        khbt_status_t        code;
    } khbt_cmd_t;

    typedef struct packed {
        logic                in_valid;
        logic                in_last;
        logic                too_long;
        logic [WSEL_W-1:0]   full_words;
        logic                kind;
        logic [SLOT_W-1:0]   fill;
        logic                match;
        logic                out_free;
    } khbt_stat_t;

    function automatic logic [63:0] rotl13(logic [63:0] x);
        return {x[50:0], x[63:51]};
    endfunction
    function automatic logic [63:0] rotl16(logic [63:0] x);
        return {x[47:0], x[63:48]};
    endfunction
    function automatic logic [63:0] rotl17(logic [63:0] x);
        return {x[46:0], x[63:47]};
    endfunction
    function automatic logic [63:0] rotl21(logic [63:0] x);
        return {x[42:0], x[63:43]};
    endfunction
    function automatic logic [63:0] rotl32(logic [63:0] x);
        return {x[31:0], x[63:32]};
    endfunction

    function automatic sip_v_t sip_round(sip_v_t vi);
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
        sip_v_t      vo;
        v0 = vi[0];
        v1 = vi[1];
        v2 = vi[2];
        v3 = vi[3];
        v0 = v0 + v1; v1 = rotl13(v1); v1 = v1 ^ v0; v0 = rotl32(v0);
        v2 = v2 + v3; v3 = rotl16(v3); v3 = v3 ^ v2;
        v0 = v0 + v3; v3 = rotl21(v3); v3 = v3 ^ v0;
        v2 = v2 + v1; v1 = rotl17(v1); v1 = v1 ^ v2; v2 = rotl32(v2);
        vo[0] = v0;
        vo[1] = v1;
        vo[2] = v2;
        vo[3] = v3;
        return vo;
    endfunction

endpackage

FILE: rtl/core/khbt_ifs.sv
// Valid/ready channel interfaces for key bytes in and results out.
// Depends on khbt_pkg for field widths.
interface khbt_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  key_byte;
    logic        last;
    logic [15:0] value_handle;
    modport source (output valid, kind, key_byte, last, value_handle, input ready);
    modport sink   (input valid, kind, key_byte, last, value_handle, output ready);
endinterface

interface khbt_res_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               status;
    logic [15:0]              found_value;
    logic [khbt_pkg::BKT_W-1:0] bucket_index;
    modport source (output valid, status, found_value, bucket_index, input ready);
    modport sink   (input valid, status, found_value, bucket_index, output ready);
endinterface

FILE: rtl/core/khbt_ctrl.sv
// Sequencer for the bucket table: byte collection, SipHash rounds,
// bucket insert or slot scan, result handoff. Depends on khbt_pkg.
module khbt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  khbt_pkg::khbt_stat_t st,
    output khbt_pkg::khbt_cmd_t  cmd
);

    khbt_pkg::khbt_state_t  state_reg, state_next;
    logic [khbt_pkg::WSEL_W-1:0] word_reg, word_next;
    logic [1:0]                  rcnt_reg, rcnt_next;
    logic [khbt_pkg::SLOT_W-1:0] slot_reg, slot_next;
    khbt_pkg::khbt_status_t      code_reg, code_next;
    logic [khbt_pkg::SLOT_W:0]   slot_inc;

    assign slot_inc = {1'b0, slot_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= khbt_pkg::S_COLLECT;
            word_reg  <= '0;
            rcnt_reg  <= '0;
            slot_reg  <= '0;
            code_reg  <= khbt_pkg::ST_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            rcnt_reg  <= rcnt_next;
            slot_reg  <= slot_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        rcnt_next  = rcnt_reg;
        slot_next  = slot_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.word   = word_reg;
        cmd.slot   = slot_reg;
        cmd.code   = code_reg;
        case (state_reg)
            khbt_pkg::S_COLLECT:
            begin
                cmd.in_ready = 1'b1;
                if (st.in_valid && st.in_last)
                    state_next = khbt_pkg::S_CHECK;
            end
            khbt_pkg::S_CHECK:
            begin
                if (st.too_long)
                begin
                    code_next  = khbt_pkg::ST_TOO_LONG;
                    state_next = khbt_pkg::S_RESULT;
                end
                else
                begin
                    cmd.init_v = 1'b1;
                    word_next  = '0;
                    state_next = khbt_pkg::S_ABS_A;
                end
            end
            khbt_pkg::S_ABS_A:
            begin
                cmd.rnd    = 1'b1;
                cmd.pre_m  = 1'b1;
                state_next = khbt_pkg::S_ABS_B;
            end
            khbt_pkg::S_ABS_B:
            begin
                cmd.rnd    = 1'b1;
                cmd.post_m = 1'b1;
                if (word_reg == st.full_words)
                begin
                    rcnt_next  = '0;
                    state_next = khbt_pkg::S_FIN;
                end
                else
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = khbt_pkg::S_ABS_A;
                end
            end
            khbt_pkg::S_FIN:
            begin
                cmd.rnd   = 1'b1;
                cmd.fin_x = (rcnt_reg == 2'd0);
                rcnt_next = rcnt_reg + 1'b1;
                if (rcnt_reg == 2'd3)
                    state_next = khbt_pkg::S_BUCKET;
            end
            khbt_pkg::S_BUCKET:
            begin
                cmd.latch_bkt = 1'b1;
                state_next    = khbt_pkg::S_DECIDE;
            end
            khbt_pkg::S_DECIDE:
            begin
                slot_next = '0;
                if (st.kind == khbt_pkg::KIND_INSERT)
                begin
                    if (st.fill >= khbt_pkg::SLOT_W'(khbt_pkg::BUCKET_SLOTS))
                    begin
                        code_next  = khbt_pkg::ST_FULL;
                        state_next = khbt_pkg::S_RESULT;
                    end
                    else
                        state_next = khbt_pkg::S_WRITE;
                end
                else if (st.fill == '0)
                begin
                    code_next  = khbt_pkg::ST_MISS;
                    state_next = khbt_pkg::S_RESULT;
                end
                else
                    state_next = khbt_pkg::S_SCAN_RD;
            end
            khbt_pkg::S_WRITE:
            begin
                cmd.wr_slot = 1'b1;
                code_next   = khbt_pkg::ST_INSERTED;
                state_next  = khbt_pkg::S_RESULT;
            end
            khbt_pkg::S_SCAN_RD:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = khbt_pkg::S_SCAN_CMP;
            end
            khbt_pkg::S_SCAN_CMP:
            begin
                if (st.match)
                begin
                    code_next  = khbt_pkg::ST_HIT;
                    state_next = khbt_pkg::S_RESULT;
                end
                else if (slot_inc < {1'b0, st.fill})
                begin
                    slot_next  = slot_inc[khbt_pkg::SLOT_W-1:0];
                    state_next = khbt_pkg::S_SCAN_RD;
                end
                else
                begin
                    code_next  = khbt_pkg::ST_MISS;
                    state_next = khbt_pkg::S_RESULT;
                end
            end
            khbt_pkg::S_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = khbt_pkg::S_COLLECT;
                end
            end
            default:
            begin
                state_next = khbt_pkg::S_COLLECT;
            end
        endcase
    end

endmodule

FILE: rtl/core/khbt_dp.sv
// Datapath: key staging, SipHash state, bucket fill counters, slot memory
// and result register. Depends on khbt_pkg and khbt_ifs.
module khbt_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    khbt_in_if.sink              in_w,
    khbt_res_if.source           res,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [63:0]          cfg_data,
    input  khbt_pkg::khbt_cmd_t  cmd,
    output khbt_pkg::khbt_stat_t st
);

    localparam int ENT_W = khbt_pkg::KEY_BITS + khbt_pkg::CNT_W + khbt_pkg::VALUE_BITS;

    logic [63:0] key_low_reg, key_high_reg;
    logic [63:0] k0_reg, k1_reg;
    logic [khbt_pkg::KEY_WORDS-1:0][63:0] staged_reg;
    logic [khbt_pkg::CNT_W-1:0]  cnt_reg;
    logic                        too_long_reg;
    logic                        kind_reg;
    logic [khbt_pkg::VALUE_BITS-1:0] handle_reg;
    khbt_pkg::sip_v_t            v_reg;
    khbt_pkg::sip_v_t            v_in, v_rnd;
    logic [khbt_pkg::BKT_W-1:0]  bucket_reg;
    logic [khbt_pkg::SLOT_W-1:0] fill_reg [khbt_pkg::NUM_BUCKETS];
    logic [ENT_W-1:0]            mem [khbt_pkg::TOTAL_SLOTS];
    logic [ENT_W-1:0]            rd_reg;
    logic [khbt_pkg::ADDR_W-1:0] base, addr;
    logic [khbt_pkg::SLOT_W-1:0] fill_cur;
    logic [khbt_pkg::WSEL_W-1:0] full_words;
    logic [63:0]                 tail, msg;
    logic [63:0]                 hash;
    logic                        take;
    logic                        out_valid_reg;
    khbt_pkg::khbt_status_t      out_status_reg;
    logic [15:0]                 out_value_reg;
    logic [khbt_pkg::BKT_W-1:0]  out_bucket_reg;

    assign take       = in_w.valid && cmd.in_ready;
    assign in_w.ready = cmd.in_ready;
    assign full_words = cnt_reg[khbt_pkg::CNT_W-1:3];
    assign fill_cur   = fill_reg[bucket_reg];
    assign base       = khbt_pkg::ADDR_W'(bucket_reg * khbt_pkg::BUCKET_SLOTS);
    assign addr       = base + khbt_pkg::ADDR_W'(cmd.wr_slot ? fill_cur : cmd.slot);

    always_comb
    begin
        tail = {2'b00, cnt_reg, 56'd0};
        if (full_words < khbt_pkg::WSEL_W'(khbt_pkg::KEY_WORDS))
            tail = tail | staged_reg[full_words[1:0]];
        msg = (cmd.word < full_words) ? staged_reg[cmd.word[1:0]] : tail;
        v_in = v_reg;
        if (cmd.pre_m)
            v_in[3] = v_reg[3] ^ msg;
        if (cmd.fin_x)
            v_in[2] = v_reg[2] ^ 64'h00000000000000FF;
        v_rnd = khbt_pkg::sip_round(v_in);
        if (cmd.post_m)
            v_rnd[0] = v_rnd[0] ^ msg;
        hash = v_reg[0] ^ v_reg[1] ^ v_reg[2] ^ v_reg[3];
    end

    // config, key latch and byte staging
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= khbt_pkg::HASH_KEY_LOW_RST;
            key_high_reg <= khbt_pkg::HASH_KEY_HIGH_RST;
            k0_reg       <= khbt_pkg::HASH_KEY_LOW_RST;
            k1_reg       <= khbt_pkg::HASH_KEY_HIGH_RST;
            staged_reg   <= '0;
            cnt_reg      <= '0;
            too_long_reg <= 1'b0;
            kind_reg     <= 1'b0;
            handle_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == khbt_pkg::CFG_KEY_LOW)
                    key_low_reg <= cfg_data;
                else
                    key_high_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                staged_reg   <= '0;
                cnt_reg      <= '0;
                too_long_reg <= 1'b0;
            end
            else if (take)
            begin
                if (cnt_reg == '0 && !too_long_reg)
                begin
                    k0_reg <= key_low_reg;
                    k1_reg <= key_high_reg;
                end
                if (cnt_reg < khbt_pkg::CNT_W'(khbt_pkg::MAX_KEY_BYTES))
                begin
                    staged_reg[cnt_reg[4:3]][cnt_reg[2:0]*8 +: 8] <= in_w.key_byte;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                    too_long_reg <= 1'b1;
                if (in_w.last)
                begin
                    kind_reg   <= in_w.kind;
                    handle_reg <= in_w.value_handle[khbt_pkg::VALUE_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_v)
        begin
            v_reg[0] <= k0_reg ^ khbt_pkg::SIP_C0;
            v_reg[1] <= k1_reg ^ khbt_pkg::SIP_C1;
            v_reg[2] <= k0_reg ^ khbt_pkg::SIP_C2;
            v_reg[3] <= k1_reg ^ khbt_pkg::SIP_C3;
        end
        else if (cmd.rnd)
            v_reg <= v_rnd;
        if (cmd.latch_bkt)
            bucket_reg <= hash[khbt_pkg::BKT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < khbt_pkg::NUM_BUCKETS; b++)
                fill_reg[b] <= '0;
        end
        else if (cmd.wr_slot)
            fill_reg[bucket_reg] <= fill_cur + 1'b1;
    end

    // slot store: key words, length, value
    always_ff @(posedge clk)
    begin
        if (cmd.wr_slot)
            mem[addr] <= {staged_reg, cnt_reg, handle_reg};
        if (cmd.rd_slot)
            rd_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.code;
            out_value_reg  <= (cmd.code == khbt_pkg::ST_HIT) ?
                              16'(rd_reg[khbt_pkg::VALUE_BITS-1:0]) : 16'd0;
            out_bucket_reg <= (cmd.code == khbt_pkg::ST_TOO_LONG) ? '0 : bucket_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = out_status_reg;
    assign res.found_value  = out_value_reg;
    assign res.bucket_index = out_bucket_reg;

    assign st.in_valid   = in_w.valid;
    assign st.in_last    = in_w.last;
    assign st.too_long   = too_long_reg;
    assign st.full_words = full_words;
    assign st.kind       = kind_reg;
    assign st.fill       = fill_cur;
    assign st.match      = (rd_reg[ENT_W-1:khbt_pkg::VALUE_BITS] == {staged_reg, cnt_reg});
    assign st.out_free   = !out_valid_reg || res.ready;

endmodule

FILE: rtl/core/keyed_hash_bucket_table_unit.sv
// Top level of the SipHash-2-4 bucketed key table: controller plus datapath.
// Depends on khbt_pkg, khbt_ifs, khbt_ctrl, khbt_dp.
//
//   port       dir   kind        contents
//   in_w       in    valid/ready kind, key_byte, last, value_handle
//   res        out   valid/ready status, found_value, bucket_index
//   cfg_*      in    write only  hash_key_low (0), hash_key_high (1)
//
// Bytes are accepted only in S_COLLECT. After the final byte: length check
// (too long goes straight to S_RESULT), SipHash rounds per absorbed word
// (bytes/8 + 1 words), final rounds, S_BUCKET, S_DECIDE, then S_WRITE or
// S_SCAN_RD/S_SCAN_CMP per slot scanned, if any, then the result load.
// No clearing pass after reset; fill counters reset to empty.
// A held result stalls S_RESULT and with it the collection of bytes.
module keyed_hash_bucket_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    khbt_in_if.sink     in_w,
    khbt_res_if.source  res,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    khbt_pkg::khbt_cmd_t  cmd;
    khbt_pkg::khbt_stat_t st;

    khbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    khbt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_w      (in_w),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
